// ===== sv/cpts_pkg.sv =====
// Shared types and constants for the curved path trapezoid step block.
// No dependencies; imported by the interfaces and every module of the block.
package cpts_pkg;

    localparam int TIME_W  = 32;
    localparam int STEP_W  = 16;
    localparam int SPEED_W = 24;
    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 24;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_START_SPEED   = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_ANGLE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_SLOPE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_CEILING = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED_FLOOR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TURN_RATE     = 3'd5;

    // Register reset values
    localparam logic signed [SPEED_W-1:0] RST_START_SPEED   = 24'sd25600;
    localparam logic [ANGLE_W-1:0]        RST_START_ANGLE   = 32'd0;
    localparam logic signed [SPEED_W-1:0] RST_SPEED_SLOPE   = 24'sd0;
    localparam logic signed [SPEED_W-1:0] RST_SPEED_CEILING = 24'sd128000;
    localparam logic signed [SPEED_W-1:0] RST_SPEED_FLOOR   = -24'sd128000;
    localparam logic [ANGLE_W-1:0]        RST_TURN_RATE     = 32'd0;

    // CORDIC datapath: Q30 values with headroom
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 33'sh026DD3B6A;
    localparam logic signed [CW-1:0] QUARTER_TURN = 33'sh040000000;

    typedef struct packed {
        logic signed [SPEED_W-1:0] start_speed;
        logic [ANGLE_W-1:0]        start_angle;
        logic signed [SPEED_W-1:0] speed_slope;
        logic signed [SPEED_W-1:0] speed_ceiling;
        logic signed [SPEED_W-1:0] speed_floor;
        logic [ANGLE_W-1:0]        turn_rate;
    } cfg_t;

    // Data that rides alongside the angles through the CORDIC stages
    typedef struct packed {
        logic signed [SPEED_W-1:0] sp0;
        logic signed [SPEED_W-1:0] sp1;
        logic [STEP_W-1:0]         dt;
    } side_t;

    function automatic logic signed [CW-1:0] arc_entry(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 33'sh020000000;
            1:  r = 33'sh012E4051E;
            2:  r = 33'sh009FB385B;
            3:  r = 33'sh0051111D4;
            4:  r = 33'sh0028B0D43;
            5:  r = 33'sh00145D7E1;
            6:  r = 33'sh000A2F61E;
            7:  r = 33'sh000517C55;
            8:  r = 33'sh00028BE53;
            9:  r = 33'sh000145F2F;
            10: r = 33'sh0000A2F98;
            11: r = 33'sh0000517CC;
            12: r = 33'sh000028BE6;
            13: r = 33'sh0000145F3;
            14: r = 33'sh000000A2FA;
            15: r = 33'sh00000517D;
            16: r = 33'sh0000028BE;
            17: r = 33'sh00000145F;
            18: r = 33'sh000000A30;
            19: r = 33'sh000000518;
            20: r = 33'sh00000028C;
            21: r = 33'sh000000146;
            22: r = 33'sh0000000A3;
            23: r = 33'sh000000051;
            24: r = 33'sh000000029;
            25: r = 33'sh000000014;
            26: r = 33'sh00000000A;
            27: r = 33'sh000000005;
            28: r = 33'sh000000003;
            29: r = 33'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/cpts_if.sv =====
// Channel interfaces of the curved path trapezoid step block.
// Depends on cpts_pkg for field widths.
interface cpts_in_if import cpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_now;
    logic [STEP_W-1:0] time_step;
    modport source (output valid, time_now, time_step, input ready);
    modport sink (input valid, time_now, time_step, output ready);
endinterface

interface cpts_out_if import cpts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] move_x;
    logic signed [OUT_W-1:0] move_y;
    modport source (output valid, move_x, move_y, input ready);
    modport sink (input valid, move_x, move_y, output ready);
endinterface

interface cpts_cfg_if import cpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/cpts_front.sv =====
// Front stages: end time, heading and speed products, then heading and clamped speed.
// Depends on cpts_pkg.
module cpts_front import cpts_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [TIME_W-1:0]          t_now,
    input  logic [STEP_W-1:0]          t_step,
    input  cfg_t                       cfg,
    output logic                       entry_valid,
    output logic                       valid_out,
    output logic [ANGLE_W-1:0]         ang0,
    output logic [ANGLE_W-1:0]         ang1,
    output side_t                      side
);

    logic              v1_reg, v2_reg, v3_reg;
    logic [TIME_W-1:0] t0_reg;
    logic [TIME_W:0]   t1_reg;
    logic [STEP_W-1:0] dt1_reg, dt2_reg;

    logic [2*ANGLE_W-1:0] ap0_full, ap1_full;
    logic signed [57:0]   slope_ext;
    logic signed [57:0]   spp0, spp1;
    logic [ANGLE_W-1:0]   ap0_reg, ap1_reg;
    logic signed [57:0]   spp0_reg, spp1_reg;

    logic [ANGLE_W-1:0]         ang0_reg, ang1_reg;
    logic signed [SPEED_W-1:0]  sp0_reg, sp1_reg;
    logic [STEP_W-1:0]          dt3_reg;

    function automatic logic signed [SPEED_W-1:0] speed_of(
        input logic signed [57:0] prod,
        input cfg_t c
    );
        logic signed [57:0] rnd;
        logic signed [57:0] base;
        logic signed [57:0] lo;
        logic signed [57:0] hi;
        logic signed [57:0] v;
        logic signed [SPEED_W-1:0] r;
        rnd  = (prod + 58'sd32768) >>> 16;
        base = c.start_speed;
        lo   = c.speed_floor;
        hi   = c.speed_ceiling;
        v    = base + rnd;
        if (v < lo) begin
            r = c.speed_floor;
        end
        else if (v > hi) begin
            r = c.speed_ceiling;
        end
        else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    // Valid bits: stage 1 loads whenever the entry stage is free or the pipe moves; the rest move with the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                v1_reg <= in_valid;
            end
            if (adv)
            begin
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: capture times, form the unwrapped end time
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t0_reg  <= t_now;
            t1_reg  <= {1'b0, t_now} + {{(TIME_W + 1 - STEP_W){1'b0}}, t_step};
            dt1_reg <= t_step;
        end
    end

    // Stage 2: heading and speed products
    assign ap0_full  = cfg.turn_rate * t0_reg;
    assign ap1_full  = cfg.turn_rate * t1_reg[TIME_W-1:0];
    assign slope_ext = cfg.speed_slope;
    assign spp0      = slope_ext * $signed({26'b0, t0_reg});
    assign spp1      = slope_ext * $signed({25'b0, t1_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ap0_reg  <= ap0_full[ANGLE_W-1:0];
            ap1_reg  <= ap1_full[ANGLE_W-1:0];
            spp0_reg <= spp0;
            spp1_reg <= spp1;
            dt2_reg  <= dt1_reg;
        end
    end

    // Stage 3: heading offset, rounded speed with clamp
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang0_reg <= cfg.start_angle + ap0_reg;
            ang1_reg <= cfg.start_angle + ap1_reg;
            sp0_reg  <= speed_of(spp0_reg, cfg);
            sp1_reg  <= speed_of(spp1_reg, cfg);
            dt3_reg  <= dt2_reg;
        end
    end

    assign entry_valid = v1_reg;
    assign valid_out   = v3_reg;
    assign ang0        = ang0_reg;
    assign ang1        = ang1_reg;
    assign side.sp0    = sp0_reg;
    assign side.sp1    = sp1_reg;
    assign side.dt     = dt3_reg;

endmodule

// ===== sv/cpts_cordic.sv =====
// Two-lane rotation-mode CORDIC pipeline, one micro-rotation per stage.
// Depends on cpts_pkg for the arctangent table, gain and side data type.
module cpts_cordic import cpts_pkg::*; #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        valid_in,
    input  logic [ANGLE_W-1:0]          ang0,
    input  logic [ANGLE_W-1:0]          ang1,
    input  side_t                       side_in,
    output logic                        valid_out,
    output logic signed [TRIG_BITS-1:0] cos0,
    output logic signed [TRIG_BITS-1:0] sin0,
    output logic signed [TRIG_BITS-1:0] cos1,
    output logic signed [TRIG_BITS-1:0] sin1,
    output side_t                       side_out
);

    localparam int F  = TRIG_BITS - 1;
    localparam int SH = 30 - F;
    localparam logic signed [CW-1:0] HALF_LSB = CW'(2 ** (SH - 1));
    localparam logic signed [CW-1:0] TRIG_MAX = CW'(2 ** F - 1);
    localparam logic signed [CW-1:0] TRIG_MIN = CW'(-(2 ** F));

    logic signed [CW-1:0] x_reg [2][CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [2][CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [2][CORDIC_STEPS+1];
    logic                 flip_reg [2][CORDIC_STEPS+1];
    side_t                side_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] vld_reg;

    logic                       vout_reg;
    logic signed [TRIG_BITS-1:0] cos_reg [2];
    logic signed [TRIG_BITS-1:0] sin_reg [2];
    side_t                      sout_reg;

    logic [ANGLE_W-1:0] ang_in [2];

    assign ang_in[0] = ang0;
    assign ang_in[1] = ang1;

    function automatic logic signed [TRIG_BITS-1:0] round_sat(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] r;
        logic signed [TRIG_BITS-1:0] o;
        r = (v + HALF_LSB) >>> SH;
        if (r > TRIG_MAX) begin
            o = TRIG_MAX[TRIG_BITS-1:0];
        end
        else if (r < TRIG_MIN) begin
            o = TRIG_MIN[TRIG_BITS-1:0];
        end
        else begin
            o = r[TRIG_BITS-1:0];
        end
        return o;
    endfunction

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[CORDIC_STEPS-1:0], valid_in};
            vout_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    // Side data follows the angles
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
            sout_reg <= side_reg[CORDIC_STEPS];
        end
    end

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        logic signed [ANGLE_W-1:0] a;
        logic                      big;
        logic [ANGLE_W-1:0]        folded;
        logic signed [CW-1:0]      xf;
        logic signed [CW-1:0]      yf;

        // Fold the back half-plane onto the front and remember to negate
        assign a      = $signed(ang_in[ln]);
        assign big    = (CW'(a) > QUARTER_TURN) || (CW'(a) < -QUARTER_TURN);
        assign folded = big ? {~ang_in[ln][ANGLE_W-1], ang_in[ln][ANGLE_W-2:0]}
                            : ang_in[ln];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[ln][0]    <= CORDIC_GAIN;
                y_reg[ln][0]    <= '0;
                z_reg[ln][0]    <= CW'($signed(folded));
                flip_reg[ln][0] <= big;
            end
        end

        for (genvar k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            assign dx = y_reg[ln][k] >>> k;
            assign dy = x_reg[ln][k] >>> k;

            // Rotate toward zero residual angle
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (z_reg[ln][k] >= 0)
                    begin
                        x_reg[ln][k+1] <= x_reg[ln][k] - dx;
                        y_reg[ln][k+1] <= y_reg[ln][k] + dy;
                        z_reg[ln][k+1] <= z_reg[ln][k] - arc_entry(k);
                    end
                    else
                    begin
                        x_reg[ln][k+1] <= x_reg[ln][k] + dx;
                        y_reg[ln][k+1] <= y_reg[ln][k] - dy;
                        z_reg[ln][k+1] <= z_reg[ln][k] + arc_entry(k);
                    end
                    flip_reg[ln][k+1] <= flip_reg[ln][k];
                end
            end
        end

        // Undo the fold, round and saturate to the trig format
        assign xf = flip_reg[ln][CORDIC_STEPS] ? -x_reg[ln][CORDIC_STEPS]
                                               : x_reg[ln][CORDIC_STEPS];
        assign yf = flip_reg[ln][CORDIC_STEPS] ? -y_reg[ln][CORDIC_STEPS]
                                               : y_reg[ln][CORDIC_STEPS];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cos_reg[ln] <= round_sat(xf);
                sin_reg[ln] <= round_sat(yf);
            end
        end
    end

    assign valid_out = vout_reg;
    assign cos0      = cos_reg[0];
    assign sin0      = sin_reg[0];
    assign cos1      = cos_reg[1];
    assign sin1      = sin_reg[1];
    assign side_out  = sout_reg;

    // The folded start angle lies within a quarter turn either way
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (z_reg[0][0] <= QUARTER_TURN) && (z_reg[0][0] >= -QUARTER_TURN)
                    && (z_reg[1][0] <= QUARTER_TURN) && (z_reg[1][0] >= -QUARTER_TURN))
        else $error("cordic start angle outside a quarter turn");

endmodule

// ===== sv/cpts_back.sv =====
// Back stages: velocity products, trapezoid sum, scale by the step, round and saturate.
// Depends on cpts_pkg.
module cpts_back import cpts_pkg::*; #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        valid_in,
    input  logic signed [TRIG_BITS-1:0] cos0,
    input  logic signed [TRIG_BITS-1:0] sin0,
    input  logic signed [TRIG_BITS-1:0] cos1,
    input  logic signed [TRIG_BITS-1:0] sin1,
    input  side_t                       side,
    output logic                        valid_out,
    output logic signed [OUT_W-1:0]     move_x,
    output logic signed [OUT_W-1:0]     move_y
);

    localparam int F  = TRIG_BITS - 1;
    localparam int PW = SPEED_W + TRIG_BITS;
    localparam int SW = PW + 1;
    localparam int MW = SW + STEP_W + 1;
    localparam logic signed [MW-1:0] HALF_LSB = MW'(1) <<< (16 + F);
    localparam logic signed [MW-1:0] OUT_MAX  = MW'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [MW-1:0] OUT_MIN  = MW'(-(2 ** (OUT_W - 1)));

    logic [3:0] v_reg;

    logic signed [PW-1:0] px0_reg, px1_reg, py0_reg, py1_reg;
    logic [STEP_W-1:0]    dt1_reg, dt2_reg, dt3_reg;
    logic signed [SW-1:0] sx, sy;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [MW-1:0] mx, my;
    logic signed [MW-1:0] mx_reg, my_reg;
    logic signed [OUT_W-1:0] ox_reg, oy_reg;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] r;
        logic signed [OUT_W-1:0] o;
        r = (v + HALF_LSB) >>> (17 + F);
        if (r > OUT_MAX) begin
            o = OUT_MAX[OUT_W-1:0];
        end
        else if (r < OUT_MIN) begin
            o = OUT_MIN[OUT_W-1:0];
        end
        else begin
            o = r[OUT_W-1:0];
        end
        return o;
    endfunction

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], valid_in};
        end
    end

    // Stage 1: speed times direction at both ends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg <= side.sp0 * cos0;
            px1_reg <= side.sp1 * cos1;
            py0_reg <= side.sp0 * sin0;
            py1_reg <= side.sp1 * sin1;
            dt1_reg <= side.dt;
        end
    end

    // Stage 2: trapezoid sum
    assign sx = SW'(px0_reg) + SW'(px1_reg);
    assign sy = SW'(py0_reg) + SW'(py1_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg  <= sx;
            sy_reg  <= sy;
            dt2_reg <= dt1_reg;
        end
    end

    // Stage 3: scale by the step length
    assign mx = MW'(sx_reg) * $signed({1'b0, dt2_reg});
    assign my = MW'(sy_reg) * $signed({1'b0, dt2_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg  <= mx;
            my_reg  <= my;
            dt3_reg <= dt2_reg;
        end
    end

    // Stage 4: round, saturate, hold for the output transaction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= round_sat(mx_reg);
            oy_reg <= round_sat(my_reg);
        end
    end

    assign valid_out = v_reg[3];
    assign move_x    = ox_reg;
    assign move_y    = oy_reg;

    // A zero step yields a zero scaled product
    a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && (dt3_reg == '0)) |-> (mx_reg == '0) && (my_reg == '0))
        else $error("nonzero product for a zero step");

endmodule

// ===== sv/curved_path_trapezoid_step_top.sv =====
// Top level of the curved path trapezoid step block: configuration registers,
// handshake control and the front, CORDIC and back pipeline sections.
// Pipeline: 39 register stages; a result that shows valid can be taken at the
// next edge.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output transaction waits, and the entry stage still fills when it is empty.
// Reset: rst_n clears all valid bits and loads the register reset values.
module curved_path_trapezoid_step_top import cpts_pkg::*; #(
    parameter int TRIG_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cpts_in_if.sink     in_ch,
    cpts_out_if.source  out_ch,
    cpts_cfg_if.sink    cfg
);

    cfg_t cfg_reg;

    logic adv;
    logic load;
    logic entry_valid;

    logic               f_valid;
    logic [ANGLE_W-1:0] f_ang0, f_ang1;
    side_t              f_side;

    logic                        c_valid;
    logic signed [TRIG_BITS-1:0] c_cos0, c_sin0, c_cos1, c_sin1;
    side_t                       c_side;

    // Configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_speed   <= RST_START_SPEED;
            cfg_reg.start_angle   <= RST_START_ANGLE;
            cfg_reg.speed_slope   <= RST_SPEED_SLOPE;
            cfg_reg.speed_ceiling <= RST_SPEED_CEILING;
            cfg_reg.speed_floor   <= RST_SPEED_FLOOR;
            cfg_reg.turn_rate     <= RST_TURN_RATE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_SPEED:   cfg_reg.start_speed   <= $signed(cfg.data[SPEED_W-1:0]);
                REG_START_ANGLE:   cfg_reg.start_angle   <= cfg.data;
                REG_SPEED_SLOPE:   cfg_reg.speed_slope   <= $signed(cfg.data[SPEED_W-1:0]);
                REG_SPEED_CEILING: cfg_reg.speed_ceiling <= $signed(cfg.data[SPEED_W-1:0]);
                REG_SPEED_FLOOR:   cfg_reg.speed_floor   <= $signed(cfg.data[SPEED_W-1:0]);
                REG_TURN_RATE:     cfg_reg.turn_rate     <= cfg.data;
                default:           ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Move the pipe when the output register is free or being taken
    assign adv         = !out_ch.valid || out_ch.ready;
    assign load        = adv || !entry_valid;
    assign in_ch.ready = load;

    cpts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .adv         (adv),
        .in_valid    (in_ch.valid),
        .t_now       (in_ch.time_now),
        .t_step      (in_ch.time_step),
        .cfg         (cfg_reg),
        .entry_valid (entry_valid),
        .valid_out   (f_valid),
        .ang0        (f_ang0),
        .ang1        (f_ang1),
        .side        (f_side)
    );

    cpts_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (f_valid),
        .ang0      (f_ang0),
        .ang1      (f_ang1),
        .side_in   (f_side),
        .valid_out (c_valid),
        .cos0      (c_cos0),
        .sin0      (c_sin0),
        .cos1      (c_cos1),
        .sin1      (c_sin1),
        .side_out  (c_side)
    );

    cpts_back #(.TRIG_BITS(TRIG_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (c_valid),
        .cos0      (c_cos0),
        .sin0      (c_sin0),
        .cos1      (c_cos1),
        .sin1      (c_sin1),
        .side      (c_side),
        .valid_out (out_ch.valid),
        .move_x    (out_ch.move_x),
        .move_y    (out_ch.move_y)
    );

    // A transaction taken during a stall sits in the entry stage
    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !adv) |=> entry_valid)
        else $error("input transaction lost during stall");

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> out_ch.valid)
        else $error("result dropped while stalled");

endmodule
